// ===== hdl/ccrq_pkg.sv =====
// Shared constants, codes and types of the cycled claim/commit ring queue.
package ccrq_pkg;

    localparam int CYCLE_SLOTS_DEF  = 16;
    localparam int CYCLE_COUNT_DEF  = 4;
    localparam int MAX_READ         = 16;
    localparam int RESULT_LIMIT     = 16;
    localparam int READ_LIMIT       = (MAX_READ < RESULT_LIMIT) ? MAX_READ : RESULT_LIMIT;

    localparam int MSG_STATE_SIZE = 4;

    localparam int MSG_BYTES_W = 10;
    localparam int STRIDE_W    = 11;
    localparam int OFF_W       = 16;
    localparam int QS_W        = 7;
    localparam int SLOT_OUT_W  = 6;
    localparam int COUNT_W     = 5;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLAIM   = 2'd0,
        REQ_COMMIT  = 2'd1,
        REQ_CONSUME = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_BACKPRESSURE = 3'd1,
        ST_ROTATED      = 3'd2,
        ST_EXHAUSTED    = 3'd3,
        ST_EMPTY        = 3'd4
    } t_status;

    typedef struct packed {
        logic    init_done;
        logic    done;
        t_status status;
        logic    zero_off;
    } t_claim_rsp;

endpackage

// ===== hdl/cycled_claim_commit_ring_queue.sv =====
// Top level of the cycled claim/commit ring queue: request sequencer, slot-busy memory, results.
//
//  channel   | dir | handshake                          | payload
//  ----------+-----+------------------------------------+-----------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tuser req_type, tdata slot, count
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tuser status, tdata, tlast last
//  cfg       | in  | i_cfg_we                           | i_cfg_wdata message_bytes
//
// A commit or unused request goes straight to its result. A claim steps through claim-word
// read, product, cached back-pressure compare, update, producer position, hand-off and
// result, with a live compare when the cached one fails and a rotate step when the cycle
// turns over; a back-pressured claim ends after the live compare. A consume walks the busy
// memory one slot a cycle until it finds a free slot or reaches the count (a count of zero
// goes straight to an empty result), then one result beat leaves per cycle while the
// output is not stalled. After reset all slots are cleared before a beat is taken.
// The output register holds a stalled beat; the next request is taken while it waits.
module cycled_claim_commit_ring_queue #(
    parameter int CYCLE_SLOTS  = ccrq_pkg::CYCLE_SLOTS_DEF,
    parameter int CYCLE_COUNT  = ccrq_pkg::CYCLE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ccrq_pkg::MSG_BYTES_W-1:0]    i_cfg_wdata,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [5:0] commit_slot, [10:6] read_count, [15:11] zero
    input  logic [ccrq_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // [1:0] req_type
    input  logic [ccrq_pkg::REQ_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [5:0] slot, [21:6] message_offset, [28:22] queue_size, [31:29] zero
    output logic [ccrq_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // [2:0] status
    output logic [ccrq_pkg::STATUS_W-1:0]       o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);
    import ccrq_pkg::*;

    localparam int                RING      = CYCLE_SLOTS * CYCLE_COUNT;
    localparam int                SLOT_W    = $clog2(RING);
    localparam int                EMIT_W    = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;
    localparam logic [SLOT_W-1:0] RING_LAST = SLOT_W'(RING - 1);
    localparam logic [EMIT_W-1:0] EMIT_LAST = EMIT_W'(RING - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLAIM_WAIT,
        S_WALK,
        S_WALK_END,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [SLOT_W-1:0]      r_clr_idx;
    logic [MSG_BYTES_W-1:0] r_msg_bytes;
    logic [63:0]            r_cons_pos;
    logic [SLOT_W-1:0]      r_cons_idx;
    logic [SLOT_W-1:0]      r_walk_idx;
    logic [COUNT_W-1:0]     r_found;
    logic [COUNT_W-1:0]     r_want;
    logic                   m_busy [RING];
    logic                   r_busy_rd;
    logic [EMIT_W-1:0]      r_emit_idx;
    logic [COUNT_W-1:0]     r_emit_left;
    t_status                r_emit_status;
    logic                   r_emit_zero;
    logic                   r_claim_start;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [SLOT_OUT_W-1:0]  r_out_slot;
    logic [OFF_W-1:0]       r_out_off;
    logic                   r_out_last;
    logic [QS_W-1:0]        r_out_qs;

    t_req                   w_req;
    logic [SLOT_OUT_W-1:0]  w_cslot;
    logic [COUNT_W-1:0]     w_rcount;
    logic [COUNT_W-1:0]     w_want;
    logic                   w_cslot_ok;
    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_out_load;
    logic [SLOT_W-1:0]      w_walk_next;
    logic                   w_walk_more;
    logic [EMIT_W-1:0]      w_emit_next;
    logic [STRIDE_W-1:0]    w_stride;
    logic [OFF_W+STRIDE_W-1:0] w_off_mul;
    logic [OFF_W-1:0]       w_off;
    logic [QS_W-1:0]        w_qs;
    logic                   w_busy_re;
    logic [SLOT_W-1:0]      w_busy_ra;
    logic                   w_busy_we;
    logic [SLOT_W-1:0]      w_busy_wa;
    logic                   w_busy_wd;
    t_claim_rsp             w_claim_rsp;
    logic [SLOT_W-1:0]      w_claim_slot;
    logic [QS_W-1:0]        w_prod_lo;

    ccrq_claim #(
        .CYCLE_SLOTS  (CYCLE_SLOTS),
        .CYCLE_COUNT  (CYCLE_COUNT)
    ) u_claim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_claim_start),
        .i_cons_pos (r_cons_pos),
        .o_rsp      (w_claim_rsp),
        .o_slot     (w_claim_slot),
        .o_prod_lo  (w_prod_lo)
    );

    assign w_req      = t_req'(i_s_axis_tuser);
    assign w_cslot    = i_s_axis_tdata[SLOT_OUT_W-1:0];
    assign w_rcount   = i_s_axis_tdata[SLOT_OUT_W +: COUNT_W];
    assign w_want     = (w_rcount > COUNT_W'(READ_LIMIT)) ? COUNT_W'(READ_LIMIT) : w_rcount;
    assign w_cslot_ok = (32'(w_cslot) < 32'(RING));
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_out_load = (r_state == S_EMIT) && w_out_free;

    assign w_walk_next = (r_walk_idx == RING_LAST) ? '0 : r_walk_idx + 1'b1;
    assign w_walk_more = r_busy_rd && ((r_found + COUNT_W'(1)) < r_want);
    assign w_emit_next = (r_emit_idx == EMIT_LAST) ? '0 : r_emit_idx + 1'b1;

    assign w_stride  = (STRIDE_W'(r_msg_bytes) + STRIDE_W'(MSG_STATE_SIZE + 3)) & ~STRIDE_W'(3);
    assign w_off_mul = OFF_W'(r_emit_idx) * w_stride;
    assign w_off     = w_off_mul[OFF_W-1:0] + OFF_W'(MSG_STATE_SIZE);
    assign w_qs      = w_prod_lo - r_cons_pos[QS_W-1:0];

    // busy memory ports
    always_comb begin
        w_busy_re = 1'b0;
        w_busy_ra = r_cons_idx;
        w_busy_we = 1'b0;
        w_busy_wa = r_walk_idx;
        w_busy_wd = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_busy_we = 1'b1;
                w_busy_wa = r_clr_idx;
            end
            S_IDLE: begin
                if (w_accept && w_req == REQ_COMMIT && w_cslot_ok) begin
                    w_busy_we = 1'b1;
                    w_busy_wa = SLOT_W'(w_cslot);
                    w_busy_wd = 1'b1;
                end
                if (w_accept && w_req == REQ_CONSUME && w_want != '0) begin
                    w_busy_re = 1'b1;
                end
            end
            S_WALK: begin
                // free the slot just seen and fetch the next one in the same cycle
                w_busy_we = r_busy_rd;
                w_busy_re = w_walk_more;
                w_busy_ra = w_walk_next;
            end
            default: begin
                w_busy_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_busy_we) begin
            m_busy[w_busy_wa] <= w_busy_wd;
        end
        if (w_busy_re) begin
            r_busy_rd <= m_busy[w_busy_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_bytes <= '0;
        end else if (i_cfg_we) begin
            r_msg_bytes <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_cons_pos    <= '0;
            r_cons_idx    <= '0;
            r_claim_start <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_claim_start <= w_accept && (w_req == REQ_CLAIM);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx != RING_LAST) begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end else if (w_claim_rsp.init_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_req)
                            REQ_CLAIM: begin
                                r_emit_left <= COUNT_W'(1);
                                r_state     <= S_CLAIM_WAIT;
                            end
                            REQ_COMMIT: begin
                                r_emit_left   <= COUNT_W'(1);
                                r_emit_zero   <= 1'b0;
                                r_emit_status <= ST_OK;
                                r_emit_idx    <= EMIT_W'(w_cslot);
                                r_state       <= S_EMIT;
                            end
                            REQ_CONSUME: begin
                                r_emit_idx  <= EMIT_W'(r_cons_idx);
                                r_emit_zero <= 1'b0;
                                if (w_want == '0) begin
                                    r_emit_left   <= COUNT_W'(1);
                                    r_emit_status <= ST_EMPTY;
                                    r_state       <= S_EMIT;
                                end else begin
                                    r_emit_status <= ST_OK;
                                    r_walk_idx    <= r_cons_idx;
                                    r_found       <= '0;
                                    r_want        <= w_want;
                                    r_state       <= S_WALK;
                                end
                            end
                            REQ_NONE: begin
                                r_emit_left   <= COUNT_W'(1);
                                r_emit_status <= ST_OK;
                                r_emit_idx    <= '0;
                                r_emit_zero   <= 1'b1;
                                r_state       <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CLAIM_WAIT: begin
                    if (w_claim_rsp.done) begin
                        // a failed claim reports slot zero
                        r_emit_idx    <= w_claim_rsp.zero_off ? '0 : EMIT_W'(w_claim_slot);
                        r_emit_status <= w_claim_rsp.status;
                        r_emit_zero   <= w_claim_rsp.zero_off;
                        r_state       <= S_EMIT;
                    end
                end
                S_WALK: begin
                    if (r_busy_rd) begin
                        r_found    <= r_found + COUNT_W'(1);
                        r_walk_idx <= w_walk_next;
                        if (!w_walk_more) begin
                            r_state <= S_WALK_END;
                        end
                    end else begin
                        r_state <= S_WALK_END;
                    end
                end
                S_WALK_END: begin
                    r_cons_pos <= r_cons_pos + 64'(r_found);
                    r_cons_idx <= r_walk_idx;
                    if (r_found == '0) begin
                        r_emit_status <= ST_EMPTY;
                        r_emit_left   <= COUNT_W'(1);
                    end else begin
                        r_emit_left <= r_found;
                    end
                    r_state <= S_WALK_END == r_state ? S_EMIT : S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_status <= r_emit_status;
                        r_out_slot   <= r_emit_idx[SLOT_OUT_W-1:0];
                        r_out_off    <= r_emit_zero ? '0 : w_off;
                        r_out_last   <= (r_emit_left == COUNT_W'(1));
                        r_out_qs     <= w_qs;
                        r_emit_left  <= r_emit_left - COUNT_W'(1);
                        r_emit_idx   <= w_emit_next;
                        if (r_emit_left == COUNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_qs, r_out_off, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY) |-> o_m_axis_tlast)
        else $error("empty-queue result without tlast");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_found < r_want))
        else $error("consume walk ran past its count");

    a_claim_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_claim_rsp.done |-> (r_state == S_CLAIM_WAIT))
        else $error("claim response with no claim pending");

    a_cons_follows_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_END) |=> (r_cons_idx == $past(r_walk_idx)))
        else $error("consumer index lost the walk position");

endmodule

// ===== hdl/ccrq_claim.sv =====
// Claim unit: claim-word memory, active cycle, back-pressure check and producer position.
module ccrq_claim #(
    parameter int  CYCLE_SLOTS  = ccrq_pkg::CYCLE_SLOTS_DEF,
    parameter int  CYCLE_COUNT  = ccrq_pkg::CYCLE_COUNT_DEF,
    localparam int SLOT_W       = $clog2(CYCLE_SLOTS * CYCLE_COUNT)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [63:0]                 i_cons_pos,
    output ccrq_pkg::t_claim_rsp        o_rsp,
    output logic [SLOT_W-1:0]           o_slot,
    output logic [ccrq_pkg::QS_W-1:0]   o_prod_lo
);
    import ccrq_pkg::*;

    localparam int              AC_W        = $clog2(CYCLE_COUNT);
    localparam int              CL_W        = $clog2(CYCLE_SLOTS + 1);
    localparam logic [CL_W-1:0] CL_K        = CL_W'(CYCLE_SLOTS);
    localparam logic [AC_W-1:0] AC_LAST     = AC_W'(CYCLE_COUNT - 1);
    localparam logic [63:0]     CLAIM_AHEAD = 64'(CYCLE_SLOTS * (CYCLE_COUNT - 1));

    typedef enum logic [2:0] {
        C_INIT,
        C_IDLE,
        C_PROD,
        C_CHK_CACHED,
        C_CHK_LIVE,
        C_UPDATE,
        C_ROTATE,
        C_SIZE
    } t_cstate;

    t_cstate            r_state;
    logic [AC_W-1:0]    r_init_idx;
    logic [AC_W-1:0]    r_active;
    logic [63:0]        m_claims [CYCLE_COUNT];
    logic [63:0]        r_rd_word;
    logic [63:0]        r_prod;
    logic [63:0]        r_cached;
    logic [63:0]        r_new_word;
    logic [QS_W-1:0]    r_prod_lo;
    logic               r_done;
    t_status            r_status;
    logic               r_zero_off;
    logic [SLOT_W-1:0]  r_slot;

    logic [31:0]        w_id;
    logic [31:0]        w_cnt;
    logic [31+CL_W:0]   w_id_mul;
    logic [63:0]        w_word_inc;
    logic [SLOT_W-1:0]  w_base;
    logic [AC_W-1:0]    w_next_ac;
    logic [31:0]        w_new_cnt;
    logic [QS_W-1:0]    w_lo_mul;
    logic [QS_W-1:0]    w_clamp;
    logic               w_live_ok;
    logic               w_we;
    logic [AC_W-1:0]    w_wa;
    logic [63:0]        w_wd;

    assign w_id       = r_rd_word[63:32];
    assign w_cnt      = r_rd_word[31:0];
    assign w_id_mul   = w_id * CL_K;
    assign w_word_inc = r_rd_word + 64'd1;
    assign w_base     = SLOT_W'(r_active) * SLOT_W'(CL_K);
    assign w_next_ac  = (r_active == AC_LAST) ? '0 : r_active + 1'b1;
    assign w_live_ok  = (r_prod < i_cons_pos + CLAIM_AHEAD);

    // producer position modulo 128 is all the queue size needs
    assign w_new_cnt = r_new_word[31:0];
    assign w_lo_mul  = QS_W'(r_new_word[32 +: QS_W]) * QS_W'(CL_K);
    assign w_clamp   = (w_new_cnt >= 32'(CYCLE_SLOTS)) ? QS_W'(CL_K) : QS_W'(w_new_cnt);

    always_comb begin
        w_we = 1'b0;
        w_wa = r_active;
        w_wd = w_word_inc;
        unique case (r_state)
            C_INIT: begin
                w_we = 1'b1;
                w_wa = r_init_idx;
                w_wd = '0;
            end
            C_UPDATE: begin
                w_we = 1'b1;
            end
            C_ROTATE: begin
                w_we = 1'b1;
                w_wa = w_next_ac;
                w_wd = {w_id + 32'd1, 32'd0};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_claims[w_wa] <= w_wd;
        end
        if (r_state == C_IDLE && i_start) begin
            r_rd_word <= m_claims[r_active];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= C_INIT;
            r_init_idx <= '0;
            r_active   <= '0;
            r_cached   <= '0;
            r_prod_lo  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= (r_state == C_SIZE) || (r_state == C_CHK_LIVE && !w_live_ok);
            unique case (r_state)
                C_INIT: begin
                    r_init_idx <= r_init_idx + 1'b1;
                    if (r_init_idx == AC_LAST) begin
                        r_state <= C_IDLE;
                    end
                end
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_PROD;
                    end
                end
                C_PROD: begin
                    r_prod  <= 64'(w_id_mul) + {32'd0, w_cnt};
                    r_state <= C_CHK_CACHED;
                end
                C_CHK_CACHED: begin
                    r_state <= (r_prod >= r_cached + CLAIM_AHEAD) ? C_CHK_LIVE : C_UPDATE;
                end
                C_CHK_LIVE: begin
                    if (w_live_ok) begin
                        r_cached <= i_cons_pos;
                        r_state  <= C_UPDATE;
                    end else begin
                        r_status   <= ST_BACKPRESSURE;
                        r_zero_off <= 1'b1;
                        r_state    <= C_IDLE;
                    end
                end
                C_UPDATE: begin
                    r_new_word <= w_word_inc;
                    r_slot     <= w_base + SLOT_W'(w_cnt);
                    if (w_cnt < 32'(CYCLE_SLOTS)) begin
                        r_status   <= ST_OK;
                        r_zero_off <= 1'b0;
                        r_state    <= C_SIZE;
                    end else if (w_cnt == 32'(CYCLE_SLOTS)) begin
                        r_status   <= ST_ROTATED;
                        r_zero_off <= 1'b1;
                        r_state    <= C_ROTATE;
                    end else begin
                        r_status   <= ST_EXHAUSTED;
                        r_zero_off <= 1'b1;
                        r_state    <= C_SIZE;
                    end
                end
                C_ROTATE: begin
                    // open the next cycle with the following id and no claims
                    r_new_word <= {w_id + 32'd1, 32'd0};
                    r_active   <= w_next_ac;
                    r_state    <= C_SIZE;
                end
                C_SIZE: begin
                    r_prod_lo <= w_lo_mul + w_clamp;
                    r_state   <= C_IDLE;
                end
                default: begin
                    r_state <= C_INIT;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.init_done = (r_state != C_INIT);
        o_rsp.done      = r_done;
        o_rsp.status    = r_status;
        o_rsp.zero_off  = r_zero_off;
    end

    assign o_slot    = r_slot;
    assign o_prod_lo = r_prod_lo;

endmodule
